@@ sv/vab_pkg.sv @@
// Shared types and constants for the vane angle bar graph.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vab_pkg;

	localparam int DATA_W  = 16;   // sample, register and pattern width
	localparam int LEVEL_W = 4;    // bar level width
	localparam int DVS_W   = 17;   // divisor width: step size reaches 65536

	localparam logic [DATA_W-1:0] BAR_BASE = 16'hfffe;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_DIV,
		ST_LEVEL,
		ST_OUT
	} vab_state_t;

	typedef struct packed {
		logic acc_en;     // add the accepted sample to the running sum
		logic frame_end;  // accepted sample closes the frame: latch total and span
		logic load_avg;   // capture clamped average and step size
		logic div_start;  // start the level division
		logic load_out;   // write the result word into the output register
	} vab_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} vab_status_t;

endpackage

@@ sv/vab_divider.sv @@
// Restoring divider, one quotient bit per cycle, used for the level division.
// Depends on vab_pkg for the divisor width.
`timescale 1ns / 1ps

module vab_divider
	import vab_pkg::*;
#(
	parameter int DVD_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops out
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ sv/vab_datapath.sv @@
// Datapath: frame accumulator, reciprocal multiplies for average and step,
// level division, output register. Depends on vab_pkg and vab_divider.
`timescale 1ns / 1ps

module vab_datapath
	import vab_pkg::*;
#(
	parameter int SAMPLES_PER_FRAME = 20,
	parameter int LED_COUNT         = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vab_cmd_t           cmd,
	output vab_status_t        status,
	input  logic [DATA_W-1:0]  sample,
	input  logic [DATA_W-1:0]  vane_zero,
	input  logic [DATA_W-1:0]  stall_vane,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [DATA_W-1:0]  led_pattern,
	output logic [LEVEL_W-1:0] bar_level,
	output logic [DATA_W-1:0]  vane_average
);

	localparam int SUM_W = DATA_W + $clog2(SAMPLES_PER_FRAME);

	// x * RCP >> SHIFT gives x / N exactly for every x below 2^W when
	// SHIFT = W + clog2(N) and RCP = ceil(2^SHIFT / N)
	localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_FRAME);
	localparam int AVG_RCP_W = SUM_W + 1;
	localparam logic [AVG_RCP_W-1:0] AVG_RCP = AVG_RCP_W'(
		((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_FRAME) - 64'd1) / 64'(SAMPLES_PER_FRAME));

	localparam int STEP_SHIFT = DATA_W + $clog2(LED_COUNT);
	localparam int STEP_RCP_W = DATA_W + 1;
	localparam logic [STEP_RCP_W-1:0] STEP_RCP = STEP_RCP_W'(
		((64'd1 << STEP_SHIFT) + 64'(LED_COUNT) - 64'd1) / 64'(LED_COUNT));

	logic [SUM_W-1:0]             sum_q;
	logic [SUM_W-1:0]             acc_next;
	logic [SUM_W-1:0]             total_q;
	logic [DATA_W-1:0]            span;
	logic [DATA_W-1:0]            span_q;
	logic [SUM_W+AVG_RCP_W-1:0]   avg_prod;
	logic [DATA_W+STEP_RCP_W-1:0] step_prod;
	logic [DATA_W-1:0]            q_avg;
	logic [DATA_W-1:0]            avg_q;
	logic [DVS_W-1:0]             step_q;
	logic [DATA_W-1:0]            dvd;
	logic [DATA_W-1:0]            quo;
	logic                         div_done;
	logic [LEVEL_W-1:0]           lvl;
	logic                         out_valid_q;
	logic [DATA_W-1:0]            pattern_q;
	logic [LEVEL_W-1:0]           level_q;
	logic [DATA_W-1:0]            out_avg_q;

	assign acc_next = sum_q + SUM_W'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.frame_end) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= acc_next;
		end
	end

	// stall below zero gives a zero span, hence a step of one
	assign span = (stall_vane >= vane_zero) ? stall_vane - vane_zero : '0;

	always_ff @(posedge clk) begin
		if (cmd.frame_end) begin
			total_q <= acc_next;
			span_q  <= span;
		end
	end

	assign avg_prod  = total_q * AVG_RCP;
	assign step_prod = span_q * STEP_RCP;
	assign q_avg     = DATA_W'(avg_prod >> AVG_SHIFT);

	always_ff @(posedge clk) begin
		if (cmd.load_avg) begin
			avg_q  <= (q_avg < vane_zero) ? vane_zero : q_avg;
			step_q <= DVS_W'(step_prod >> STEP_SHIFT) + DVS_W'(1);
		end
	end

	assign dvd = avg_q - vane_zero;

	vab_divider #(
		.DVD_W(DATA_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (step_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign lvl = (quo > DATA_W'(LED_COUNT)) ? LEVEL_W'(LED_COUNT) : quo[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pattern_q <= BAR_BASE << lvl;
			level_q   <= lvl;
			out_avg_q <= avg_q;
		end
	end

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign led_pattern  = pattern_q;
	assign bar_level    = level_q;
	assign vane_average = out_avg_q;

endmodule

@@ sv/vab_ctrl.sv @@
// Controller: sample counter, input flow control and the per-frame
// sequence of average, step and level. Depends on vab_pkg.
`timescale 1ns / 1ps

module vab_ctrl
	import vab_pkg::*;
#(
	parameter int SAMPLES_PER_FRAME = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  vab_status_t status,
	output vab_cmd_t    cmd
);

	localparam int CNT_W = $clog2(SAMPLES_PER_FRAME + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_FRAME - 1);

	vab_state_t       state_q;
	vab_state_t       state_nxt;
	logic [CNT_W-1:0] count_q;
	logic             last_smp;
	logic             acc;

	assign last_smp = count_q == LAST;
	// the closing word of a frame waits until the previous frame is done
	assign in_ready = !(last_smp && state_q != ST_IDLE);
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (acc) begin
				count_q <= last_smp ? '0 : count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		cmd.acc_en    = acc;
		cmd.frame_end = acc && last_smp;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && last_smp) begin
					state_nxt = ST_AVG;
				end
			end
			ST_AVG: begin
				cmd.load_avg = 1'b1;
				state_nxt    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_LEVEL;
			end
			ST_LEVEL: begin
				if (status.div_done) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/vane_angle_bar_graph.sv @@
// Top level of the vane angle bar graph: configuration registers and the
// controller and datapath. Depends on vab_pkg, vab_ctrl and vab_datapath.
`timescale 1ns / 1ps

// Usage
//   s_*   : one vane sample per word. A frame of SAMPLES_PER_FRAME words
//           gives one result word on m_*; other words give none.
//   m_*   : led_pattern, bar_level and clamped vane_average of the frame.
//   APB   : vane_zero at 0x0, stall_vane at 0x4, written and read back.
// From the closing word of a frame, the result passes through the
// reciprocal multiplies that give average and step size, the start of the
// level division, the restoring divider, the state that sees it done and
// the output register before m_tvalid rises.
// Throughput: every word but the closing one of a frame is taken each
// cycle; the closing word is held off while the previous frame is still
// in progress or its result cannot enter the output register.
// A stalled m_tready holds the result; samples but closing words keep flowing.
// Reset clears the frame sum and count, sets vane_zero to 0 and
// stall_vane to 0xffff, and empties the output register.

module vane_angle_bar_graph
	import vab_pkg::*;
#(
	parameter int SAMPLES_PER_FRAME = 20,
	parameter int LED_COUNT         = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] vane_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] led_pattern, [19:16] bar_level,
	                               // [35:20] vane_average, [39:36] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [DATA_W-1:0]  zero_q;
	logic [DATA_W-1:0]  stall_q;
	logic               cfg_wr;
	vab_cmd_t           dp_cmd;
	vab_status_t        dp_status;
	logic [DATA_W-1:0]  led_pattern;
	logic [LEVEL_W-1:0] bar_level;
	logic [DATA_W-1:0]  vane_average;
	logic [DATA_W-1:0]  exp_pattern;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q  <= '0;
			stall_q <= 16'hffff;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				stall_q <= pwdata[DATA_W-1:0];
			end else begin
				zero_q <= pwdata[DATA_W-1:0];
			end
		end
	end

	assign prdata = paddr[2] ? {16'b0, stall_q} : {16'b0, zero_q};

	vab_ctrl #(
		.SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	vab_datapath #(
		.SAMPLES_PER_FRAME(SAMPLES_PER_FRAME),
		.LED_COUNT        (LED_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.sample       (s_tdata),
		.vane_zero    (zero_q),
		.stall_vane   (stall_q),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.led_pattern  (led_pattern),
		.bar_level    (bar_level),
		.vane_average (vane_average)
	);

	assign m_tdata = {4'b0, vane_average, bar_level, led_pattern};

	assign exp_pattern = BAR_BASE << m_tdata[19:16];

	a_level_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[19:16] <= LEVEL_W'(LED_COUNT))
		else $error("bar level above LED count");

	a_pattern_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] == exp_pattern)
		else $error("bar pattern does not match level");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

endmodule
